// ===== rtl/bdasc_pkg.sv =====
// Shared types, constants and helpers for the binary to decimal ASCII converter.
package bdasc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int CFG_W       = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CHAR_W      = 6;
    localparam int TDATA_W     = 8;
    localparam int NUM_DIG     = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W       = NUM_DIG * 4;
    localparam int CNT_W       = $clog2(NUM_DIG + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0]  DIG_CAP    = CFG_W'(10);
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DIGITS = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DIGITS = CFG_ADDR_W'(1);

    typedef logic [VALUE_WIDTH-1:0]  t_value;
    typedef logic [NUM_DIG-1:0][3:0] t_bcd;

    typedef struct packed {
        logic   valid;
        t_value value;
    } t_q_head;

    function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] v;
        v = r;
        if (v == '0) v = CFG_W'(1);
        if (v > DIG_CAP) v = DIG_CAP;
        return v;
    endfunction

endpackage

// ===== rtl/bdasc_front.sv =====
// Input side: accepts value beats into a short queue ahead of the converter.
module bdasc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [bdasc_pkg::IN_W-1:0] i_s_axis_tdata,  // [31:0] value
    output bdasc_pkg::t_q_head        o_head,
    input  logic                      i_pop
);
    import bdasc_pkg::*;

    t_value               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 push;
    logic                 pop;

    assign o_s_axis_tready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.value = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= VALUE_WIDTH'(i_s_axis_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + Q_PTR_W'(1);
            if (pop)  r_rptr <= r_rptr + Q_PTR_W'(1);
            case ({push, pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/bdasc_conv.sv =====
// Back end: serial double-dabble, digit count, and per-digit output register.
module bdasc_conv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bdasc_pkg::t_q_head           i_head,
    output logic                         o_pop,
    input  logic [bdasc_pkg::CFG_W-1:0]  i_lo,
    input  logic [bdasc_pkg::CFG_W-1:0]  i_hi,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [bdasc_pkg::TDATA_W-1:0] o_m_axis_tdata,  // [5:0] digit_char, [7:6] zero
    output logic                         o_m_axis_tlast,
    output logic [0:0]                   o_m_axis_tuser    // [0] truncated
);
    import bdasc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    t_value                r_sh;
    t_bcd                  r_bcd;
    logic [BIT_CNT_W-1:0]  r_bitcnt;
    logic [CFG_W-1:0]      r_pos;
    logic                  r_trunc;
    logic                  r_ovalid;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_olast;
    logic                  r_otrunc;

    t_bcd                  adj;
    logic [BCD_W-1:0]      adj_flat;
    logic [CNT_W-1:0]      nd;
    logic [CFG_W-1:0]      count;
    logic                  trunc;
    logic [3:0]            cur_digit;
    logic                  load;

    always_comb begin
        for (int i = 0; i < NUM_DIG; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
    end
    assign adj_flat = adj;

    // significant digit count, then clamp against min / max
    always_comb begin
        nd = CNT_W'(1);
        for (int i = 0; i < NUM_DIG; i++) begin
            if (r_bcd[i] != 4'd0) nd = CNT_W'(i + 1);
        end
        count = (int'(nd) < int'(i_lo)) ? i_lo : CFG_W'(nd);
        trunc = 1'b0;
        if (int'(nd) > int'(i_hi) || int'(count) > int'(i_hi)) begin
            trunc = (int'(nd) > int'(i_hi));
            count = i_hi;
        end
    end

    always_comb begin
        cur_digit = 4'd0;
        for (int i = 0; i < NUM_DIG; i++) begin
            if (int'(r_pos) == i) cur_digit = r_bcd[i];
        end
    end

    assign load  = (r_state == S_EMIT) && (!r_ovalid || i_m_axis_tready);
    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_head.valid) n_state = S_SHIFT;
            S_SHIFT: if (r_bitcnt == BIT_CNT_W'(VALUE_WIDTH - 1)) n_state = S_SCAN;
            S_SCAN:  n_state = S_EMIT;
            S_EMIT:  if (load && r_pos == '0) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_sh     <= i_head.value;
                r_bcd    <= '0;
                r_bitcnt <= '0;
            end
            S_SHIFT: begin
                r_bcd    <= t_bcd'({adj_flat[BCD_W-2:0], r_sh[VALUE_WIDTH-1]});
                r_sh     <= {r_sh[VALUE_WIDTH-2:0], 1'b0};
                r_bitcnt <= r_bitcnt + BIT_CNT_W'(1);
            end
            S_SCAN: begin
                r_pos   <= count - CFG_W'(1);
                r_trunc <= trunc;
            end
            S_EMIT: begin
                if (load) begin
                    r_char   <= ASCII_ZERO + CHAR_W'(cur_digit);
                    r_olast  <= (r_pos == '0);
                    r_otrunc <= r_trunc;
                    r_pos    <= r_pos - CFG_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = TDATA_W'(r_char);
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_otrunc;

endmodule

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// Top level: configuration registers, input queue and serial converter.
// Per value: a pick-up state, one double-dabble shift per input bit, a count state,
// then one digit beat per digit, for 1 to 10 digits.
// A two-entry queue takes new values while the converter is busy.
// Synchronous active-low reset empties the queue, idles the converter and
// sets min_digits to 1 and max_digits to 10.
module binary_to_decimal_ascii_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [bdasc_pkg::IN_W-1:0]        i_s_axis_tdata,  // [31:0] value
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [bdasc_pkg::TDATA_W-1:0]     o_m_axis_tdata,  // [5:0] digit_char, [7:6] zero
    output logic                              o_m_axis_tlast,
    output logic [0:0]                        o_m_axis_tuser,  // [0] truncated
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bdasc_pkg::CFG_ADDR_W-1:0]  i_cfg_index,
    input  logic [bdasc_pkg::CFG_W-1:0]       i_cfg_data
);
    import bdasc_pkg::*;

    logic [CFG_W-1:0] r_min_digits;
    logic [CFG_W-1:0] r_max_digits;
    t_q_head          head;
    logic             pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_digits <= CFG_W'(1);
            r_max_digits <= CFG_W'(10);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MIN_DIGITS: r_min_digits <= i_cfg_data;
                REG_MAX_DIGITS: r_max_digits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bdasc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_head          (head),
        .i_pop           (pop)
    );

    bdasc_conv u_conv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .i_lo            (clamp_count(r_min_digits)),
        .i_hi            (clamp_count(r_max_digits)),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== rtl/bdasc_check.sv =====
// Port-level checks for the converter top, attached by bind.
module bdasc_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [bdasc_pkg::TDATA_W-1:0]     o_m_axis_tdata,
    input logic                              o_m_axis_tlast,
    input logic [0:0]                        o_m_axis_tuser
);
    import bdasc_pkg::*;

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("outputs not cleared by reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
         && $stable(o_m_axis_tuser)))
        else $error("stalled result beat changed");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:6] == 2'b00 &&
                             o_m_axis_tdata[5:0] >= 6'd48 && o_m_axis_tdata[5:0] <= 6'd57))
        else $error("result beat is not a decimal digit");

    a_trunc_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) ##1 o_m_axis_tvalid
        |-> $stable(o_m_axis_tuser))
        else $error("truncation flag changed inside a value");

endmodule

bind binary_to_decimal_ascii_top bdasc_check u_bdasc_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== dv/testbench.sv =====
// Testbench for binary_to_decimal_ascii_top: random and directed values checked per digit beat.
module testbench;
    import bdasc_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              trunc;
    } t_digit_beat;

    class decimal_text_model;
        logic [CFG_W-1:0] min_reg;
        logic [CFG_W-1:0] max_reg;
        t_digit_beat      pending_chars[$];
        int               errors;

        function new();
            min_reg = CFG_W'(1);
            max_reg = CFG_W'(10);
            errors  = 0;
        endfunction

        function int limit_count(logic [CFG_W-1:0] r);
            int n;
            n = r;
            if (n == 0) n = 1;
            if (n > 10) n = 10;
            return n;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_MIN_DIGITS) min_reg = data;
            else if (idx == REG_MAX_DIGITS) max_reg = data;
        endfunction

        // expands one accepted value into its expected digit beats
        function void note_value(logic [IN_W-1:0] v);
            logic [3:0]       dig[10];
            logic [IN_W-1:0]  rest;
            int               nd, lo, hi, cnt, pos;
            bit               tr;
            t_digit_beat      b;
            for (int i = 0; i < 10; i++) dig[i] = 4'd0;
            rest = v;
            nd   = 0;
            do begin
                dig[nd] = 4'(rest % 10);
                rest    = rest / 10;
                nd++;
            end while (rest != 0);
            lo  = limit_count(min_reg);
            hi  = limit_count(max_reg);
            cnt = (nd < lo) ? lo : nd;
            tr  = 1'b0;
            if (cnt > hi) begin
                tr  = (nd > hi);
                cnt = hi;
            end
            for (int k = 0; k < cnt; k++) begin
                pos     = cnt - 1 - k;
                b.ch    = ASCII_ZERO + CHAR_W'(dig[pos]);
                b.last  = (k + 1 == cnt);
                b.trunc = tr;
                pending_chars.push_back(b);
            end
        endfunction

        function void check_char(logic [TDATA_W-1:0] data, logic last, logic trunc);
            t_digit_beat e;
            if (pending_chars.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected digit beat: tdata=%h last=%b trunc=%b",
                             data, last, trunc);
                return;
            end
            e = pending_chars.pop_front();
            if (data !== {{(TDATA_W-CHAR_W){1'b0}}, e.ch} || last !== e.last
                    || trunc !== e.trunc) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp tdata=%h last=%b trunc=%b, ",
                              "got tdata=%h last=%b trunc=%b"},
                             {{(TDATA_W-CHAR_W){1'b0}}, e.ch}, e.last, e.trunc,
                             data, last, trunc);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic [0:0]            o_m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    int src_idle_pct = 12;
    int snk_idle_pct = 50;

    decimal_text_model chars_h = new();

    binary_to_decimal_ascii_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // digit sink: check each beat, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            chars_h.check_char(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser[0]);
        i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_value(input logic [IN_W-1:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= v;
        do @(posedge i_clk); while (!o_s_axis_tready);
        chars_h.note_value(v);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        chars_h.set_reg(idx, data);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (chars_h.pending_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_digits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        wait_drained();
        write_reg(REG_MIN_DIGITS, lo);
        write_reg(REG_MAX_DIGITS, hi);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] ext[4];
        logic [CFG_W-1:0] lo, hi;
        logic [IN_W-1:0]  v, p;
        ext = '{4'd0, 4'd1, 4'd10, 4'd15};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no padding, up to ten digits
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1000000000);
        send_value(32'd999999999);
        send_value(32'h8000_0000);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
        // zero minimum, saturated maximum
        set_digits(4'd0, 4'd15);
        send_value(32'd0);
        send_value(32'd5);
        send_value(32'hFFFF_FFFF);
        // saturated minimum pads to ten
        set_digits(4'd15, 4'd10);
        send_value(32'd0);
        send_value(32'd12345);
        // maximum below minimum
        set_digits(4'd4, 4'd2);
        send_value(32'd7);
        send_value(32'd123456);
        set_digits(4'd10, 4'd1);
        send_value(32'd98765);
        send_value(32'd3);
        // zero maximum acts as one
        set_digits(4'd1, 4'd0);
        send_value(32'd42);
        send_value(32'd0);
        set_digits(4'd3, 4'd5);
        send_value(32'd1234567);
        send_value(32'd12);
        send_value(32'd99999);

        for (int blk = 0; blk < 12; blk++) begin
            if (blk < 4) begin
                lo = ext[blk];
                hi = ext[3-blk];
            end else begin
                lo = CFG_W'($urandom_range(15));
                hi = CFG_W'($urandom_range(15));
            end
            set_digits(lo, hi);
            case (blk / 4)
                0: begin src_idle_pct = 12; snk_idle_pct = 50; end
                1: begin src_idle_pct = 50; snk_idle_pct = 12; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int n = 0; n < 34; n++) begin
                case ($urandom_range(4))
                    0: v = $urandom;
                    1: v = $urandom_range(999);
                    2: begin
                        p = 1;
                        repeat ($urandom_range(9)) p = p * 10;
                        v = p + $urandom_range(2) - 1;
                    end
                    3: v = $urandom >> $urandom_range(31);
                    default: v = 32'hFFFF_FFFF - $urandom_range(9);
                endcase
                send_value(v);
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (chars_h.errors == 0 && chars_h.pending_chars.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
